FILE: rtl/lav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;

  localparam int POS_W       = 32;
  localparam int VEC_W       = 16;
  localparam int RGT_W       = 2 * VEC_W + 1;
  localparam int CUP_W       = VEC_W + RGT_W;
  localparam int FRAC        = 16;
  localparam int FWD_FRAC    = 14;
  localparam int NRM_W       = FRAC + 2;
  localparam int DOT_W       = 53;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0]       ROW_FIRST = 2'd0;
  localparam logic [1:0]       ROW_LAST  = 2'd3;
  localparam logic [POS_W-1:0] ONE_Q16   = 32'h0001_0000;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][VEC_W-1:0] fwd;
    logic [2:0][RGT_W-1:0] rgt;
    logic [2:0][CUP_W-1:0] cup;
  } work_t;

  function automatic logic [POS_W-1:0] sat32(input logic signed [DOT_W-1:0] x);
    logic [DOT_W-POS_W:0] top;
    top = x[DOT_W-1:POS_W-1];
    if (top == '0 || top == '1) begin
      sat32 = x[POS_W-1:0];
    end else if (x[DOT_W-1]) begin
      sat32 = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lav_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module lav_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = lav_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  input  logic [W-1:0] wr_data,
  output logic         wr_ready,
  output logic         rd_valid,
  output logic [W-1:0] rd_data,
  input  logic         rd_take
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_take && rd_valid;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lav_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lav_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [15:0]  fwd_x,
  input  logic signed [15:0]  fwd_y,
  input  logic signed [15:0]  fwd_z,
  input  logic signed [15:0]  up_x,
  input  logic signed [15:0]  up_y,
  input  logic signed [15:0]  up_z,
  output logic                wr_valid,
  output lav_pkg::work_t      wr_data,
  input  logic                wr_ready
);

  logic adv;
  logic f1_v;
  logic f2_v;

  logic [2:0][lav_pkg::POS_W-1:0]        f1_pos;
  logic signed [lav_pkg::VEC_W-1:0]      f1_f [3];
  logic signed [lav_pkg::RGT_W-1:0]      f1_r [3];
  logic [2:0][lav_pkg::POS_W-1:0]        f2_pos;
  logic signed [lav_pkg::VEC_W-1:0]      f2_f [3];
  logic signed [lav_pkg::RGT_W-1:0]      f2_r [3];
  logic signed [lav_pkg::CUP_W-1:0]      f2_c [3];

  assign adv      = !(f2_v && !wr_ready);
  assign in_stall = !adv;
  assign wr_valid = f2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else if (adv) begin
      f1_v <= in_valid;
      f2_v <= f1_v;
    end
  end

  // right = up x forward
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_pos  <= {pos_z, pos_y, pos_x};
      f1_f[0] <= fwd_x;
      f1_f[1] <= fwd_y;
      f1_f[2] <= fwd_z;
      f1_r[0] <= up_y * fwd_z - up_z * fwd_y;
      f1_r[1] <= up_z * fwd_x - up_x * fwd_z;
      f1_r[2] <= up_x * fwd_y - up_y * fwd_x;
    end
  end

  // corrected up = forward x right
  always_ff @(posedge clk) begin
    if (adv) begin
      f2_pos  <= f1_pos;
      f2_f    <= f1_f;
      f2_r    <= f1_r;
      f2_c[0] <= f1_f[1] * f1_r[2] - f1_f[2] * f1_r[1];
      f2_c[1] <= f1_f[2] * f1_r[0] - f1_f[0] * f1_r[2];
      f2_c[2] <= f1_f[0] * f1_r[1] - f1_f[1] * f1_r[0];
    end
  end

  always_comb begin
    wr_data.pos = f2_pos;
    for (int i = 0; i < 3; i++) begin
      wr_data.fwd[i] = f2_f[i];
      wr_data.rgt[i] = f2_r[i];
      wr_data.cup[i] = f2_c[i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lav_norm.sv
`timescale 1ns / 1ps
`default_nettype none
module lav_norm #(
  parameter int VW = lav_pkg::CUP_W,
  parameter int SW = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [2:0][VW-1:0]                in_vec,
  input  logic [SW-1:0]                     in_side,
  output logic                              out_valid,
  output logic [2:0][lav_pkg::NRM_W-1:0]    out_nrm,
  output logic [SW-1:0]                     out_side,
  output logic                              out_zero
);

  localparam int MW   = VW - 1;
  localparam int LW   = (MW + 1) / 2;
  localparam int HW   = MW - LW;
  localparam int RW   = MW + 1;
  localparam int SQW  = 2 * RW;
  localparam int REMW = RW + 1;
  localparam int QB   = lav_pkg::FRAC + 1;

  typedef struct packed {
    logic [SW-1:0]         side;
    logic [2:0][MW-1:0]    mag;
    logic [2:0]            neg;
    logic                  zero;
  } carry_t;

  carry_t              a_c;
  carry_t              b_c;
  carry_t              c_c;
  logic                a_v;
  logic                b_v;
  logic                c_v;
  logic [2:0][VW-1:0]  a_abs;
  logic [2*HW-1:0]     b_hh [3];
  logic [HW+LW-1:0]    b_hl [3];
  logic [2*LW-1:0]     b_ll [3];
  logic [2*MW-1:0]     c_sq [3];

  logic [SQW-1:0]      sq_n    [RW+1];
  logic [REMW-1:0]     sq_rem  [RW+1];
  logic [RW-1:0]       sq_root [RW+1];
  carry_t              sq_c    [RW+1];
  logic                sq_v    [RW+1];

  logic [REMW-1:0]     dv_r   [QB][3];
  logic [QB-1:0]       dv_q   [QB][3];
  logic [RW-1:0]       dv_len [QB];
  carry_t              dv_c   [QB];
  logic                dv_v   [QB];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_abs[i] = in_vec[i][VW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v     <= 1'b0;
      b_v     <= 1'b0;
      c_v     <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      a_v     <= in_valid;
      b_v     <= a_v;
      c_v     <= b_v;
      sq_v[0] <= c_v;
    end
  end

  // magnitude, split squares, squares, sum of squares
  always_ff @(posedge clk) begin
    if (adv) begin
      a_c.side <= in_side;
      a_c.zero <= in_vec == '0;
      for (int i = 0; i < 3; i++) begin
        a_c.mag[i] <= a_abs[i][MW-1:0];
        a_c.neg[i] <= in_vec[i][VW-1];
      end
      b_c <= a_c;
      for (int i = 0; i < 3; i++) begin
        b_hh[i] <= a_c.mag[i][MW-1:LW] * a_c.mag[i][MW-1:LW];
        b_hl[i] <= a_c.mag[i][MW-1:LW] * a_c.mag[i][LW-1:0];
        b_ll[i] <= a_c.mag[i][LW-1:0] * a_c.mag[i][LW-1:0];
      end
      c_c <= b_c;
      for (int i = 0; i < 3; i++) begin
        c_sq[i] <= {b_hh[i], {(2*LW){1'b0}}} + {b_hl[i], {(LW+1){1'b0}}} + b_ll[i];
      end
      sq_c[0]    <= c_c;
      sq_n[0]    <= SQW'(c_sq[0]) + SQW'(c_sq[1]) + SQW'(c_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // floor square root, one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+1:0] remx;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      remx  = {sq_rem[k][RW-1:0], sq_n[k][SQW-1:SQW-2]};
      trial = {sq_root[k], 2'b01};
      ge    = remx >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n[k+1]    <= {sq_n[k][SQW-3:0], 2'b00};
        sq_rem[k+1]  <= ge ? REMW'(remx - trial) : REMW'(remx);
        sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
        sq_c[k+1]    <= sq_c[k];
      end
    end
  end

  // magnitude * 2^16 / length, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [REMW-1:0] r_in [3];
    logic [QB-1:0]   q_in [3];
    logic [RW-1:0]   len_in;
    carry_t          c_in;
    logic            v_in;
    logic [REMW-1:0] x [3];
    logic [2:0]      ge;

    if (j == 0) begin : g_first
      always_comb begin
        len_in = sq_root[RW];
        c_in   = sq_c[RW];
        v_in   = sq_v[RW];
        for (int i = 0; i < 3; i++) begin
          r_in[i] = REMW'(sq_c[RW].mag[i]);
          q_in[i] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        len_in = dv_len[j-1];
        c_in   = dv_c[j-1];
        v_in   = dv_v[j-1];
        for (int i = 0; i < 3; i++) begin
          r_in[i] = dv_r[j-1][i];
          q_in[i] = dv_q[j-1][i];
        end
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        x[i]  = (j == 0) ? r_in[i] : {r_in[i][RW-1:0], 1'b0};
        ge[i] = x[i] >= REMW'(len_in);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (adv) begin
        dv_v[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_len[j] <= len_in;
        dv_c[j]   <= c_in;
        for (int i = 0; i < 3; i++) begin
          dv_r[j][i] <= ge[i] ? x[i] - REMW'(len_in) : x[i];
          dv_q[j][i] <= {q_in[i][QB-2:0], ge[i]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= dv_c[QB-1].side;
      out_zero <= dv_c[QB-1].zero;
      for (int i = 0; i < 3; i++) begin
        if (dv_c[QB-1].zero) begin
          out_nrm[i] <= '0;
        end else if (dv_c[QB-1].neg[i]) begin
          out_nrm[i] <= ~{1'b0, dv_q[QB-1][i]} + 1'b1;
        end else begin
          out_nrm[i] <= {1'b0, dv_q[QB-1][i]};
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lav_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lav_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  lav_pkg::work_t      in_data,
  output logic                in_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          row_index,
  output logic signed [31:0]  elem_0,
  output logic signed [31:0]  elem_1,
  output logic signed [31:0]  elem_2,
  output logic signed [31:0]  elem_3,
  output logic                degenerate,
  output logic                last_row
);

  localparam int PW  = lav_pkg::POS_W;
  localparam int FW  = lav_pkg::VEC_W;
  localparam int NW  = lav_pkg::NRM_W;
  localparam int DW  = lav_pkg::DOT_W;
  localparam int CW  = lav_pkg::CUP_W;
  localparam int RGW = lav_pkg::RGT_W;

  logic                        adv;
  logic                        hold_can;
  logic                        load;
  logic [2:0][CW-1:0]          r_ext;

  logic                        nr_valid;
  logic [2:0][NW-1:0]          nr_nrm;
  logic [3*PW-1:0]             nr_pos;
  logic                        nr_zero;
  logic                        nc_valid;
  logic [2:0][NW-1:0]          nc_nrm;
  logic [3*FW-1:0]             nc_fwd;
  logic                        nc_zero;

  logic                        d1_v;
  logic                        d1_deg;
  logic [2:0][NW-1:0]          d1_rn;
  logic [2:0][NW-1:0]          d1_un;
  logic [3*FW-1:0]             d1_fwd;
  logic signed [PW+NW-1:0]     d1_pr [3];
  logic signed [PW+NW-1:0]     d1_pu [3];
  logic signed [PW+FW-1:0]     d1_pf [3];

  logic signed [DW-1:0]        s_r;
  logic signed [DW-1:0]        s_u;
  logic signed [DW-1:0]        s_f;

  logic                        h_v;
  logic [1:0]                  row;
  logic                        h_deg;
  logic [2:0][NW-1:0]          h_rn;
  logic [2:0][NW-1:0]          h_un;
  logic [3*FW-1:0]             h_fwd;
  logic [PW-1:0]               h_dr;
  logic [PW-1:0]               h_du;
  logic [PW-1:0]               h_df;

  logic [NW-1:0]               rn_sel;
  logic [NW-1:0]               un_sel;
  logic [FW-1:0]               f_sel;

  assign hold_can = !h_v || (row == lav_pkg::ROW_LAST && !out_stall);
  assign adv      = !d1_v || hold_can;
  assign load     = d1_v && hold_can;
  assign in_take  = adv && in_valid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_ext[i] = {{(CW-RGW){in_data.rgt[i][RGW-1]}}, in_data.rgt[i]};
    end
  end

  lav_norm #(
    .VW (CW),
    .SW (3 * PW)
  ) u_norm_rgt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_vec    (r_ext),
    .in_side   (in_data.pos),
    .out_valid (nr_valid),
    .out_nrm   (nr_nrm),
    .out_side  (nr_pos),
    .out_zero  (nr_zero)
  );

  lav_norm #(
    .VW (CW),
    .SW (3 * FW)
  ) u_norm_cup (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_vec    (in_data.cup),
    .in_side   (in_data.fwd),
    .out_valid (nc_valid),
    .out_nrm   (nc_nrm),
    .out_side  (nc_fwd),
    .out_zero  (nc_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
    end else if (adv) begin
      d1_v <= nr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_deg <= nr_zero || nc_zero;
      d1_rn  <= nr_nrm;
      d1_un  <= nc_nrm;
      d1_fwd <= nc_fwd;
      for (int i = 0; i < 3; i++) begin
        d1_pr[i] <= $signed(nr_nrm[i]) * $signed(nr_pos[i*PW +: PW]);
        d1_pu[i] <= $signed(nc_nrm[i]) * $signed(nr_pos[i*PW +: PW]);
        d1_pf[i] <= $signed(nc_fwd[i*FW +: FW]) * $signed(nr_pos[i*PW +: PW]);
      end
    end
  end

  always_comb begin
    s_r = DW'(d1_pr[0]) + DW'(d1_pr[1]) + DW'(d1_pr[2]);
    s_u = -(DW'(d1_pu[0]) + DW'(d1_pu[1]) + DW'(d1_pu[2]));
    s_f = DW'(d1_pf[0]) + DW'(d1_pf[1]) + DW'(d1_pf[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
      row <= lav_pkg::ROW_FIRST;
    end else begin
      if (load) begin
        h_v <= 1'b1;
      end else if (h_v && !out_stall && row == lav_pkg::ROW_LAST) begin
        h_v <= 1'b0;
      end
      if (h_v && !out_stall) begin
        row <= row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h_deg <= d1_deg;
      h_rn  <= d1_rn;
      h_un  <= d1_un;
      h_fwd <= d1_fwd;
      h_dr  <= lav_pkg::sat32(s_r >>> lav_pkg::FRAC);
      h_du  <= lav_pkg::sat32(s_u >>> lav_pkg::FRAC);
      h_df  <= lav_pkg::sat32(s_f >>> lav_pkg::FWD_FRAC);
    end
  end

  always_comb begin
    rn_sel = h_rn[0];
    un_sel = h_un[0];
    f_sel  = h_fwd[0 +: FW];
    case (row)
      2'd1: begin
        rn_sel = h_rn[1];
        un_sel = h_un[1];
        f_sel  = h_fwd[FW +: FW];
      end
      2'd2: begin
        rn_sel = h_rn[2];
        un_sel = h_un[2];
        f_sel  = h_fwd[2*FW +: FW];
      end
      default: begin
        rn_sel = h_rn[0];
        un_sel = h_un[0];
        f_sel  = h_fwd[0 +: FW];
      end
    endcase
  end

  always_comb begin
    if (row == lav_pkg::ROW_LAST) begin
      elem_0 = h_dr;
      elem_1 = h_du;
      elem_2 = h_df;
      elem_3 = lav_pkg::ONE_Q16;
    end else begin
      elem_0 = -{{(PW-NW){rn_sel[NW-1]}}, rn_sel};
      elem_1 = {{(PW-NW){un_sel[NW-1]}}, un_sel};
      elem_2 = -{{(PW-FW-2){f_sel[FW-1]}}, f_sel, 2'b00};
      elem_3 = '0;
    end
  end

  assign out_valid  = h_v;
  assign row_index  = row;
  assign degenerate = h_deg;
  assign last_row   = row == lav_pkg::ROW_LAST;

  a_row_idle: assert property (@(posedge clk) disable iff (rst)
    !h_v |-> row == lav_pkg::ROW_FIRST)
    else $error("row counter not at first row while hold is empty");

  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    h_v && out_stall |=> h_v && row == $past(row))
    else $error("row moved while output stalled");

  a_norm_align: assert property (@(posedge clk) disable iff (rst)
    nr_valid == nc_valid)
    else $error("normalize pipelines out of step");

endmodule
`default_nettype wire

FILE: rtl/look_at_view_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake              Payload
// input    in_valid / in_stall    pos_x..z, fwd_x..z, up_x..z
// output   out_valid / out_stall  row_index, elem_0..3, degenerate, last_row
//
// Each transaction in yields four transactions out, rows 0 to 3.
// The four-row serializer loads a new input only as the last row of the one before leaves.
// Most of the pipeline depth is the 49-stage square root and the 17-stage divide.
// Reset (rst, synchronous) empties the pipeline and the queue; no clearing pass.
// Back end halts on out_stall once d1 is full; the queue lets the front keep taking input.
module look_at_view_matrix #(
  parameter int QUEUE_DEPTH = lav_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [15:0]  fwd_x,
  input  logic signed [15:0]  fwd_y,
  input  logic signed [15:0]  fwd_z,
  input  logic signed [15:0]  up_x,
  input  logic signed [15:0]  up_y,
  input  logic signed [15:0]  up_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          row_index,
  output logic signed [31:0]  elem_0,
  output logic signed [31:0]  elem_1,
  output logic signed [31:0]  elem_2,
  output logic signed [31:0]  elem_3,
  output logic                degenerate,
  output logic                last_row
);

  logic           q_wr_valid;
  logic           q_wr_ready;
  lav_pkg::work_t q_wr_data;
  logic           q_rd_valid;
  lav_pkg::work_t q_rd_data;
  logic           q_rd_take;

  lav_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .fwd_x    (fwd_x),
    .fwd_y    (fwd_y),
    .fwd_z    (fwd_z),
    .up_x     (up_x),
    .up_y     (up_y),
    .up_z     (up_z),
    .wr_valid (q_wr_valid),
    .wr_data  (q_wr_data),
    .wr_ready (q_wr_ready)
  );

  lav_fifo #(
    .W     ($bits(lav_pkg::work_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_data  (q_wr_data),
    .wr_ready (q_wr_ready),
    .rd_valid (q_rd_valid),
    .rd_data  (q_rd_data),
    .rd_take  (q_rd_take)
  );

  lav_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_rd_valid),
    .in_data    (q_rd_data),
    .in_take    (q_rd_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_index  (row_index),
    .elem_0     (elem_0),
    .elem_1     (elem_1),
    .elem_2     (elem_2),
    .elem_3     (elem_3),
    .degenerate (degenerate),
    .last_row   (last_row)
  );

endmodule
`default_nettype wire
